>>> hw/rtl/bracket_balance_checker_defines.svh
// Assertion macros for the bracket balance checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define BBC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bbc: same-cycle check failed");

// Check that cons holds in the cycle after ante holds.
`define BBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bbc: next-cycle check failed");

`endif

>>> hw/rtl/bbc_pkg.sv
// Shared types, constants and the character classifier of the bracket balance checker.
// No dependencies; used by bbc_stack_mem and bracket_balance_checker.
`default_nettype none

package bbc_pkg;

    localparam int unsigned DEFAULT_STACK_DEPTH = 64;

    localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;  // (
    localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;  // )
    localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;  // ]
    localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;  // {
    localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;  // }

    localparam logic [1:0] VERDICT_PENDING = 2'd0;
    localparam logic [1:0] VERDICT_VALID   = 2'd1;
    localparam logic [1:0] VERDICT_INVALID = 2'd2;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_OPEN  = 2'd1,
        CLS_CLOSE = 2'd2
    } t_cls;

    typedef struct packed {
        t_cls  cls;
        t_kind kind;
    } t_class;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic       failed_so_far;
    } t_out_item;

    function automatic t_class classify(input logic [7:0] c);
        t_class r;
        r.cls  = CLS_OTHER;
        r.kind = KIND_ROUND;
        case (c)
            CHAR_ROUND_OPEN:   begin r.cls = CLS_OPEN;  r.kind = KIND_ROUND;  end
            CHAR_SQUARE_OPEN:  begin r.cls = CLS_OPEN;  r.kind = KIND_SQUARE; end
            CHAR_CURLY_OPEN:   begin r.cls = CLS_OPEN;  r.kind = KIND_CURLY;  end
            CHAR_ROUND_CLOSE:  begin r.cls = CLS_CLOSE; r.kind = KIND_ROUND;  end
            CHAR_SQUARE_CLOSE: begin r.cls = CLS_CLOSE; r.kind = KIND_SQUARE; end
            CHAR_CURLY_CLOSE:  begin r.cls = CLS_CLOSE; r.kind = KIND_CURLY;  end
            default:           begin r.cls = CLS_OTHER; r.kind = KIND_ROUND;  end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bracket_balance_checker.sv
// Top level of the bracket balance checker: issue stage, stack memory, verdict stage.
// Depends on bbc_pkg, bbc_stack_mem and bracket_balance_checker_defines.svh.
//
//  channel | valid       | stall        | payload                     | dir
//  --------+-------------+--------------+-----------------------------+-----
//  in      | i_in_valid  | o_in_stall   | i_in_item  (t_in_item)      | in
//  out     | o_out_valid | i_out_stall  | o_out_item (t_out_item)     | out
//
// Throughput is one item per cycle while i_out_stall is low. An accepted item
// passes the issue register, then the verdict register; the stack memory read
// that a closing bracket needs before its kind compare is registered in step
// with the issue register.
// Reset (i_rst_n low at a clock edge) empties both stages, the stack count and
// the failure flag; the stack memory itself is never cleared.
// i_out_stall holds the verdict register; the issue stage then fills and
// o_in_stall rises once both stages hold an item.
`default_nettype none

`include "bracket_balance_checker_defines.svh"

module bracket_balance_checker #(
    parameter int unsigned STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bbc_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output bbc_pkg::t_out_item o_out_item
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

    // ------------------------------------------------------------------
    // Handshake: a two-register pipeline with a shared advance chain.
    // ------------------------------------------------------------------
    logic out_free;    // verdict register can load this cycle
    logic a_move;      // issue stage hands its item to the verdict register
    logic a_free;      // issue stage can load this cycle
    logic in_accept;

    logic r_a_valid;
    logic r_o_valid;

    assign out_free   = !r_o_valid || !i_out_stall;
    assign a_move     = r_a_valid && out_free;
    assign a_free     = !r_a_valid || a_move;
    assign in_accept  = i_in_valid && a_free;
    assign o_in_stall = !a_free;

    // ------------------------------------------------------------------
    // Issue: classify, move the stack pointer, start the memory access.
    // The count moves at acceptance, so a later pop always reads after the
    // push that wrote its entry; no two accesses to one entry overlap.
    // Once the string has failed, the stack may drift: its contents no
    // longer matter until the end-of-string clear.
    // ------------------------------------------------------------------
    bbc_pkg::t_class cls;
    logic            cnt_full;
    logic            cnt_empty;
    logic            do_push;
    logic            do_pop;
    logic            op_err;
    logic [CW-1:0]   cnt_after;
    logic [CW-1:0]   cnt_dec;

    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;

    always_comb begin
        cls       = bbc_pkg::classify(i_in_item.char_code);
        cnt_full  = (r_cnt == CNT_FULL);
        cnt_empty = (r_cnt == '0);
        cnt_dec   = r_cnt - CW'(1);
        op_err    = 1'b0;
        cnt_after = r_cnt;
        unique case (cls.cls)
            bbc_pkg::CLS_OPEN: begin
                op_err = cnt_full;
                if (!cnt_full) begin
                    cnt_after = r_cnt + CW'(1);
                end
            end
            bbc_pkg::CLS_CLOSE: begin
                op_err = cnt_empty;
                if (!cnt_empty) begin
                    cnt_after = cnt_dec;
                end
            end
            bbc_pkg::CLS_OTHER: begin
                op_err = 1'b0;
            end
            default: begin
                op_err = 1'b0;
            end
        endcase
        do_push = in_accept && (cls.cls == bbc_pkg::CLS_OPEN) && !cnt_full;
        do_pop  = in_accept && (cls.cls == bbc_pkg::CLS_CLOSE) && !cnt_empty;

        // Drop the stack at the end of a string.
        n_cnt = r_cnt;
        if (in_accept) begin
            n_cnt = i_in_item.last_char ? '0 : cnt_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    bbc_pkg::t_kind rd_kind;

    bbc_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (do_push),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_kind (cls.kind),
        .i_rd_en   (do_pop),
        .i_rd_addr (cnt_dec[AW-1:0]),
        .o_rd_kind (rd_kind)
    );

    // Issue-stage register: what the verdict stage needs besides the read data.
    logic           r_a_pop;
    bbc_pkg::t_kind r_a_kind;
    logic           r_a_err;
    logic           r_a_last;
    logic           r_a_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_pop  <= do_pop;
            r_a_kind <= cls.kind;
            r_a_err  <= op_err;
            r_a_last <= i_in_item.last_char;
            r_a_nz   <= (cnt_after != '0);
        end
    end

    // ------------------------------------------------------------------
    // Verdict: compare the popped kind, fold in the sticky flag, decide.
    // ------------------------------------------------------------------
    logic               r_fail;
    logic               fail_now;
    bbc_pkg::t_out_item out_next;

    always_comb begin
        fail_now = r_fail || r_a_err || (r_a_pop && (rd_kind != r_a_kind));
        out_next.failed_so_far = fail_now;
        if (!r_a_last) begin
            out_next.verdict = bbc_pkg::VERDICT_PENDING;
        end else if (fail_now || r_a_nz) begin
            out_next.verdict = bbc_pkg::VERDICT_INVALID;
        end else begin
            out_next.verdict = bbc_pkg::VERDICT_VALID;
        end
    end

    // Clear the flag after the last character of a string.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail <= 1'b0;
        end else if (a_move) begin
            r_fail <= r_a_last ? 1'b0 : fail_now;
        end
    end

    bbc_pkg::t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BBC_ASSERT_SAME(a_cnt_in_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_FULL)
    `BBC_ASSERT_NEXT(a_last_clears_cnt, i_clk, i_rst_n, in_accept && i_in_item.last_char, r_cnt == '0)
    `BBC_ASSERT_NEXT(a_rd_holds, i_clk, i_rst_n, r_a_valid && r_a_pop && !a_move, $stable(rd_kind))

endmodule

`default_nettype wire

>>> hw/rtl/bbc_stack_mem.sv
// Bracket stack storage: one write port, one read port with registered read data.
// Depends on bbc_pkg for the kind type and the default depth.
`default_nettype none

module bbc_stack_mem #(
    parameter int unsigned STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH,
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire bbc_pkg::t_kind i_wr_kind,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output bbc_pkg::t_kind     o_rd_kind
);

    bbc_pkg::t_kind r_mem [STACK_DEPTH];
    bbc_pkg::t_kind r_rd_kind;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_kind;
        end
    end

    // Hold read data until the next read so a waiting pop keeps its operand.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_kind <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_kind = r_rd_kind;

endmodule

`default_nettype wire
